### rtl/efc_pkg.sv
// Shared types and constants of the envelope frame checker.
package efc_pkg;

  localparam int unsigned HeaderBytes = 20;
  localparam int unsigned CountWidth  = 33;
  localparam int unsigned NumChannels = 5;
  localparam int unsigned CfgIdxWidth = 8;

  localparam logic [CountWidth-1:0] CountMax = '1;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_TRUNC    = 3'd1,
    ST_MAGIC    = 3'd2,
    ST_VERSION  = 3'd3,
    ST_CHANNEL  = 3'd4,
    ST_ZERO_ID  = 3'd5,
    ST_LENGTH   = 3'd6,
    ST_MISMATCH = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_STATUS  = 2'd2
  } out_kind_e;

  localparam logic [CfgIdxWidth-1:0] RegMagic   = 8'd0;
  localparam logic [CfgIdxWidth-1:0] RegVersion = 8'd1;
  localparam logic [CfgIdxWidth-1:0] RegLimit1  = 8'd2;
  localparam logic [CfgIdxWidth-1:0] RegLimit2  = 8'd3;
  localparam logic [CfgIdxWidth-1:0] RegLimit3  = 8'd4;
  localparam logic [CfgIdxWidth-1:0] RegLimit4  = 8'd5;
  localparam logic [CfgIdxWidth-1:0] RegLimit5  = 8'd6;

  localparam logic [31:0] Limit1Reset = 32'(64 * 1024);
  localparam logic [31:0] Limit2Reset = 32'(4 * 1024 * 1024);
  localparam logic [31:0] Limit3Reset = 32'(1 * 1024 * 1024);
  localparam logic [31:0] Limit4Reset = 32'(1 * 1024 * 1024);
  localparam logic [31:0] Limit5Reset = 32'(256 * 1024);

  typedef struct packed {
    logic [15:0]                  magic;
    logic [7:0]                   version;
    logic [NumChannels-1:0][31:0] limit;
  } cfg_regs_t;

  typedef struct packed {
    out_kind_e   out_kind;
    logic        frame_end;
    logic [7:0]  channel_id;
    logic [15:0] message_kind;
    logic [15:0] message_flags;
    logic [63:0] request_number;
    logic [31:0] payload_length;
    logic [7:0]  payload_byte;
    status_e     status;
  } result_t;

endpackage

### rtl/efc_intf.sv
// Channel interfaces of the envelope frame checker: byte input, result output, register writes.
interface efc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_frame;

  modport source (output valid, data_byte, end_of_frame, input ready);
  modport sink (input valid, data_byte, end_of_frame, output ready);
endinterface

interface efc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic        frame_end;
  logic [7:0]  channel_id;
  logic [15:0] message_kind;
  logic [15:0] message_flags;
  logic [63:0] request_number;
  logic [31:0] payload_length;
  logic [7:0]  payload_byte;
  logic [2:0]  status;

  modport source (output valid, out_kind, frame_end, channel_id, message_kind, message_flags,
                  request_number, payload_length, payload_byte, status, input ready);
  modport sink (input valid, out_kind, frame_end, channel_id, message_kind, message_flags,
                request_number, payload_length, payload_byte, status, output ready);
endinterface

interface efc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/envelope_frame_checker.sv
// Envelope frame checker top level: header parse, checks, payload forwarding and status.
//
//   channel   dir   payload                                      handshake
//   in_i      in    data_byte, end_of_frame                      valid/ready
//   out_o     out   out_kind ... status (one result record)      valid/ready
//   cfg_i     in    index, data (register write)                 valid/ready
//
// One byte is taken per clock; each byte is parsed and checked in the cycle it is
// accepted, and its result, if any, lands in a single output register.
// in_i.ready is high while that register is empty or being drained in the same cycle,
// so a stalled output holds at most one result and input stops only while it waits.
// The 33-bit byte counter and the end-of-payload compare set the per-byte path.
// Reset clears the counter, the error code and the output valid; no clearing pass.
module envelope_frame_checker (
  input  logic    clk_i,
  input  logic    rst_ni,
  efc_in_if.sink  in_i,
  efc_out_if.source out_o,
  efc_cfg_if.sink cfg_i
);
  import efc_pkg::*;

  cfg_regs_t              regs;
  logic [CountWidth-1:0]  cnt_q, cnt_d, cnt_inc, end_q, end_d;
  logic [63:0]            shift_q, shift_d, req_q, req_d;
  logic [7:0]             chan_q, chan_d;
  logic [15:0]            kind_q, kind_d, flags_q, flags_d;
  logic [31:0]            limit_q, limit_d;
  status_e                err_q, err_d;
  result_t                res, out_q;
  logic                   res_vld, out_valid_q, acc, fwd;

  efc_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .regs_o (regs)
  );

  assign acc        = in_i.valid && in_i.ready;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign cnt_inc    = cnt_q + CountWidth'(1);

  always_comb begin
    logic       in_hdr;
    logic [4:0] hpos;
    logic       eof;
    logic [7:0] b;

    b       = in_i.data_byte;
    eof     = in_i.end_of_frame;
    in_hdr  = cnt_q < CountWidth'(HeaderBytes);
    hpos    = cnt_q[4:0];
    shift_d = {shift_q[55:0], b};
    cnt_d   = (cnt_q == CountMax) ? cnt_q : cnt_inc;
    err_d   = err_q;
    chan_d  = chan_q;
    kind_d  = kind_q;
    flags_d = flags_q;
    req_d   = req_q;
    limit_d = limit_q;
    end_d   = end_q;
    fwd     = 1'b0;
    res_vld = 1'b0;
    res     = '0;

    if (in_hdr) begin
      unique case (hpos)
        5'd1: if (err_d == ST_OK && shift_d[15:0] != regs.magic) err_d = ST_MAGIC;
        5'd2: if (err_d == ST_OK && b != regs.version) err_d = ST_VERSION;
        5'd3: begin
          chan_d = b;
          unique case (b)
            8'd1: limit_d = regs.limit[0];
            8'd2: limit_d = regs.limit[1];
            8'd3: limit_d = regs.limit[2];
            8'd4: limit_d = regs.limit[3];
            8'd5: limit_d = regs.limit[4];
            default: begin
              limit_d = '0;
              if (err_d == ST_OK) err_d = ST_CHANNEL;
            end
          endcase
        end
        5'd5:  kind_d  = shift_d[15:0];
        5'd7:  flags_d = shift_d[15:0];
        5'd15: req_d   = shift_d;
        default: ;
      endcase

      if (hpos == 5'(HeaderBytes - 1)) begin
        // Last header byte: final checks and the header record.
        end_d = {1'b0, shift_d[31:0]} + CountWidth'(HeaderBytes);
        if (err_d == ST_OK && req_q == '0) err_d = ST_ZERO_ID;
        if (err_d == ST_OK && (shift_d[31:0] == '0 || shift_d[31:0] > limit_q)) begin
          err_d = ST_LENGTH;
        end
        res_vld            = 1'b1;
        res.out_kind       = KIND_HEADER;
        res.channel_id     = chan_q;
        res.message_kind   = kind_q;
        res.message_flags  = flags_q;
        res.request_number = req_q;
        res.payload_length = shift_d[31:0];
        if (eof) begin
          res.frame_end = 1'b1;
          res.status    = (err_d != ST_OK) ? err_d : ST_MISMATCH;
        end
      end else if (eof) begin
        // A short header outranks any error already found.
        res_vld       = 1'b1;
        res.out_kind  = KIND_STATUS;
        res.frame_end = 1'b1;
        res.status    = ST_TRUNC;
      end
    end else begin
      fwd = (err_q == ST_OK) && (cnt_q < end_q);
      if (fwd) begin
        res_vld          = 1'b1;
        res.out_kind     = KIND_PAYLOAD;
        res.payload_byte = b;
        if (eof) begin
          res.frame_end = 1'b1;
          res.status    = (cnt_inc == end_q) ? ST_OK : ST_MISMATCH;
        end
      end else begin
        if (err_d == ST_OK) err_d = ST_MISMATCH;
        if (eof) begin
          res_vld       = 1'b1;
          res.out_kind  = KIND_STATUS;
          res.frame_end = 1'b1;
          res.status    = err_d;
        end
      end
    end

    if (eof) begin
      cnt_d   = '0;
      shift_d = '0;
      err_d   = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      shift_q <= '0;
      err_q   <= ST_OK;
    end else if (acc) begin
      cnt_q   <= cnt_d;
      shift_q <= shift_d;
      err_q   <= err_d;
    end
  end

  // Held header fields carry no reset; each is written before it is read in a frame.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      chan_q  <= chan_d;
      kind_q  <= kind_d;
      flags_q <= flags_d;
      req_q   <= req_d;
      limit_q <= limit_d;
      end_q   <= end_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (acc && res_vld) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && res_vld) begin
      out_q <= res;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.out_kind       = out_q.out_kind;
  assign out_o.frame_end      = out_q.frame_end;
  assign out_o.channel_id     = out_q.channel_id;
  assign out_o.message_kind   = out_q.message_kind;
  assign out_o.message_flags  = out_q.message_flags;
  assign out_o.request_number = out_q.request_number;
  assign out_o.payload_length = out_q.payload_length;
  assign out_o.payload_byte   = out_q.payload_byte;
  assign out_o.status         = out_q.status;

`ifndef SYNTHESIS
  // Any transaction that ends a frame restarts the byte count and the error code.
  a_eof_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && in_i.end_of_frame |=> cnt_q == '0 && err_q == ST_OK)
    else $error("frame end did not restart the parser");

  // A nonzero status is only reported on a result that closes the frame.
  a_status_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status != ST_OK |-> out_q.frame_end)
    else $error("status reported without frame end");

  // Payload is forwarded only after the full header and while no error is held.
  a_fwd_after_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && fwd |-> cnt_q >= CountWidth'(HeaderBytes) && err_q == ST_OK)
    else $error("payload forwarded inside header or after an error");

  // A fresh result never overwrites one that the sink has not taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> out_valid_q && $stable(out_q))
    else $error("pending result lost");
`endif

endmodule

### rtl/efc_cfg_regs.sv
// Configuration register file: magic, version and the five channel length limits.
module efc_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  efc_cfg_if.sink           cfg_i,
  output efc_pkg::cfg_regs_t regs_o
);
  import efc_pkg::*;

  cfg_regs_t regs_q;
  logic      wr;

  assign cfg_i.ready = 1'b1;
  assign wr          = cfg_i.valid && cfg_i.ready;
  assign regs_o      = regs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.magic    <= '0;
      regs_q.version  <= '0;
      regs_q.limit[0] <= Limit1Reset;
      regs_q.limit[1] <= Limit2Reset;
      regs_q.limit[2] <= Limit3Reset;
      regs_q.limit[3] <= Limit4Reset;
      regs_q.limit[4] <= Limit5Reset;
    end else if (wr) begin
      // Writes to an index beyond the list are dropped.
      unique case (cfg_i.index)
        RegMagic:   regs_q.magic    <= cfg_i.data[15:0];
        RegVersion: regs_q.version  <= cfg_i.data[7:0];
        RegLimit1:  regs_q.limit[0] <= cfg_i.data;
        RegLimit2:  regs_q.limit[1] <= cfg_i.data;
        RegLimit3:  regs_q.limit[2] <= cfg_i.data;
        RegLimit4:  regs_q.limit[3] <= cfg_i.data;
        RegLimit5:  regs_q.limit[4] <= cfg_i.data;
        default: ;
      endcase
    end
  end

endmodule

### test/efc_record_checker.sv
// Record checker for the envelope frame checker: predicts each result record and compares it.
`timescale 1ns / 100ps

module efc_record_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  efc_in_if           in_i,
  efc_out_if          out_i,
  efc_cfg_if          cfg_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import efc_pkg::*;

  // Register copies, written as the block sees its register transactions.
  logic [15:0] cfg_magic;
  logic [7:0]  cfg_version;
  logic [31:0] cfg_limit [NumChannels];

  // Frame parse state.
  logic [CountWidth-1:0] byte_cnt;
  logic [63:0]           hdr_shift;
  logic [7:0]            held_chan;
  logic [15:0]           held_kind;
  logic [15:0]           held_flags;
  logic [63:0]           held_req;
  logic [31:0]           held_len;
  logic [31:0]           held_lim;
  status_e               first_err;

  result_t     frame_records_q[$];
  int unsigned bad_record_cnt;

  assign fail_count_o = bad_record_cnt;

  function automatic void flag_error(input status_e code);
    if (first_err == ST_OK) first_err = code;
  endfunction

  function automatic void close_frame();
    byte_cnt  = '0;
    hdr_shift = '0;
    first_err = ST_OK;
  endfunction

  // Works out the record, if any, that one accepted byte produces.
  function automatic void parse_frame_byte(input logic [7:0] data, input logic last);
    logic [CountWidth-1:0] pos;
    logic [CountWidth-1:0] pay_pos;
    result_t rec;
    pos = byte_cnt;
    if (byte_cnt != CountMax) byte_cnt = byte_cnt + 1'b1;
    rec = '0;
    if (pos < HeaderBytes) begin
      hdr_shift = {hdr_shift[55:0], data};
      case (pos)
        1: if (hdr_shift[15:0] != cfg_magic) flag_error(ST_MAGIC);
        2: if (hdr_shift[7:0] != cfg_version) flag_error(ST_VERSION);
        3: begin
          held_chan = hdr_shift[7:0];
          if (held_chan >= 1 && held_chan <= NumChannels) begin
            held_lim = cfg_limit[held_chan - 1];
          end else begin
            held_lim = '0;
            flag_error(ST_CHANNEL);
          end
        end
        5: held_kind = hdr_shift[15:0];
        7: held_flags = hdr_shift[15:0];
        15: held_req = hdr_shift;
        default: ;
      endcase
      if (pos == HeaderBytes - 1) begin
        held_len = hdr_shift[31:0];
        if (held_req == '0) flag_error(ST_ZERO_ID);
        if (held_len == '0 || held_len > held_lim) flag_error(ST_LENGTH);
        rec.out_kind       = KIND_HEADER;
        rec.channel_id     = held_chan;
        rec.message_kind   = held_kind;
        rec.message_flags  = held_flags;
        rec.request_number = held_req;
        rec.payload_length = held_len;
        if (last) begin
          // A frame that ends right on the header can never match a nonzero length.
          rec.frame_end = 1'b1;
          rec.status    = (first_err != ST_OK) ? first_err : ST_MISMATCH;
          close_frame();
        end
        frame_records_q = {frame_records_q, rec};
      end else if (last) begin
        rec.out_kind  = KIND_STATUS;
        rec.frame_end = 1'b1;
        rec.status    = ST_TRUNC;
        close_frame();
        frame_records_q = {frame_records_q, rec};
      end
      return;
    end
    if (first_err == ST_OK) begin
      pay_pos = pos - HeaderBytes;
      if (pay_pos < {1'b0, held_len}) begin
        rec.out_kind     = KIND_PAYLOAD;
        rec.payload_byte = data;
        if (last) begin
          rec.frame_end = 1'b1;
          rec.status    = (pay_pos + 1'b1 == {1'b0, held_len}) ? ST_OK : ST_MISMATCH;
          close_frame();
        end
        frame_records_q = {frame_records_q, rec};
        return;
      end
      flag_error(ST_MISMATCH);
    end
    if (last) begin
      rec.out_kind  = KIND_STATUS;
      rec.frame_end = 1'b1;
      rec.status    = first_err;
      close_frame();
      frame_records_q = {frame_records_q, rec};
    end
  endfunction

  function automatic string show_record(input result_t r);
    return $sformatf({"kind=%0d end=%0b chan=%0d mkind=%h flags=%h req=%h len=%h",
                      " byte=%h status=%0d"},
                     r.out_kind, r.frame_end, r.channel_id, r.message_kind, r.message_flags,
                     r.request_number, r.payload_length, r.payload_byte, r.status);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t seen;
    result_t want;
    if (!rst_ni) begin
      cfg_magic    = '0;
      cfg_version  = '0;
      cfg_limit[0] = Limit1Reset;
      cfg_limit[1] = Limit2Reset;
      cfg_limit[2] = Limit3Reset;
      cfg_limit[3] = Limit4Reset;
      cfg_limit[4] = Limit5Reset;
      held_chan    = '0;
      held_kind    = '0;
      held_flags   = '0;
      held_req     = '0;
      held_len     = '0;
      held_lim     = '0;
      close_frame();
      frame_records_q.delete();
      bad_record_cnt = 0;
      pending_o <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == RegMagic) begin
          cfg_magic = cfg_i.data[15:0];
        end else if (cfg_i.index == RegVersion) begin
          cfg_version = cfg_i.data[7:0];
        end else if (cfg_i.index >= RegLimit1 && cfg_i.index <= RegLimit5) begin
          cfg_limit[cfg_i.index - RegLimit1] = cfg_i.data;
        end
      end
      if (out_i.valid && out_i.ready) begin
        seen.out_kind       = out_kind_e'(out_i.out_kind);
        seen.frame_end      = out_i.frame_end;
        seen.channel_id     = out_i.channel_id;
        seen.message_kind   = out_i.message_kind;
        seen.message_flags  = out_i.message_flags;
        seen.request_number = out_i.request_number;
        seen.payload_length = out_i.payload_length;
        seen.payload_byte   = out_i.payload_byte;
        seen.status         = status_e'(out_i.status);
        if (frame_records_q.size() == 0) begin
          bad_record_cnt++;
          if (bad_record_cnt <= 10)
            $display("%0t: unexpected record %s", $time, show_record(seen));
        end else begin
          want = frame_records_q.pop_front();
          if (seen !== want) begin
            bad_record_cnt++;
            if (bad_record_cnt <= 10) begin
              $display("%0t: record differs, expected %s", $time, show_record(want));
              $display("%0t:                  actual %s", $time, show_record(seen));
            end
          end
        end
      end
      if (in_i.valid && in_i.ready) parse_frame_byte(in_i.data_byte, in_i.end_of_frame);
      pending_o <= frame_records_q.size();
    end
  end

endmodule

### test/testbench.sv
// Top of the envelope frame checker test: clock, reset, frame stimulus and the verdict.
`timescale 1ns / 100ps

module testbench;
  import efc_pkg::*;

  typedef enum int {
    FR_GOOD,
    FR_SHORT_HEADER,
    FR_BAD_MAGIC,
    FR_BAD_VERSION,
    FR_BAD_CHANNEL,
    FR_ZERO_ID,
    FR_ZERO_LENGTH,
    FR_OVER_LIMIT,
    FR_TOO_LONG,
    FR_TOO_SHORT,
    FR_END_AT_HEADER,
    FR_NOISE
  } frame_flavor_e;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_HALF,
    READY_SPARSE,
    READY_PERIODIC
  } ready_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned bytes_sent = 0;
  int unsigned burst_left = 0;
  ready_mode_e ready_mode = READY_ALWAYS;
  int unsigned ready_hold = 0;

  // Register values as the block should hold them, used to build legal headers.
  logic [15:0] cur_magic;
  logic [7:0]  cur_version;
  logic [31:0] cur_limit [NumChannels];
  logic [31:0] next_limit [NumChannels];

  efc_in_if  in_if ();
  efc_out_if out_if ();
  efc_cfg_if cfg_if ();

  envelope_frame_checker i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  efc_record_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_if),
    .out_i        (out_if),
    .cfg_i        (cfg_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // The result side's ready follows modes, from always ready to sparse, that each last a random stretch of cycles.
  always @(posedge clk_i) begin
    if (ready_hold == 0) begin
      ready_mode <= ready_mode_e'($urandom_range(0, 3));
      ready_hold <= $urandom_range(16, 160);
    end else begin
      ready_hold <= ready_hold - 1;
    end
    case (ready_mode)
      READY_ALWAYS: out_if.ready <= 1'b1;
      READY_HALF: out_if.ready <= 1'($urandom_range(0, 1));
      READY_SPARSE: out_if.ready <= ($urandom_range(0, 3) == 0);
      default: out_if.ready <= ready_hold[2];
    endcase
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Sends one byte; bytes go out in bursts of random length with random gaps.
  task automatic put_byte(input logic [7:0] data, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 7);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    in_if.valid        <= 1'b1;
    in_if.data_byte    <= data;
    in_if.end_of_frame <= last;
    do @(posedge clk_i); while (!in_if.ready);
    bytes_sent++;
  endtask

  // Leaves cfg valid high; the caller lowers it after the last write.
  task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == RegMagic) begin
      cur_magic = val[15:0];
    end else if (idx == RegVersion) begin
      cur_version = val[7:0];
    end else if (idx >= RegLimit1 && idx <= RegLimit5) begin
      cur_limit[idx - RegLimit1] = val;
    end
  endtask

  // Writes every register, with junk in the unused upper bits, then an unused index.
  task automatic apply_settings(input logic [15:0] magic, input logic [7:0] ver,
                                input logic [7:0] stray_idx);
    write_reg(RegMagic, {16'($urandom), magic});
    write_reg(RegVersion, {24'($urandom), ver});
    for (int k = 0; k < NumChannels; k++) write_reg(8'(RegLimit1 + k), next_limit[k]);
    write_reg(stray_idx, $urandom);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_frame(input frame_flavor_e flavor);
    logic [15:0]  magic;
    logic [7:0]   ver;
    logic [7:0]   chan;
    logic [15:0]  kind;
    logic [15:0]  flags;
    logic [63:0]  req;
    logic [31:0]  len;
    logic [31:0]  lim;
    logic [159:0] hdr;
    int unsigned  n;
    int unsigned  cut;
    logic [7:0]   frame_q[$];
    magic = cur_magic;
    ver   = cur_version;
    chan  = 8'($urandom_range(1, NumChannels));
    kind  = 16'($urandom);
    flags = 16'($urandom);
    req   = {$urandom, $urandom};
    if (req == '0) req = 64'd1;
    lim = cur_limit[chan - 1];
    len = $urandom_range(1, (lim < 16) ? lim : 16);
    n   = len;
    cut = 0;
    case (flavor)
      FR_SHORT_HEADER: begin
        if ($urandom_range(0, 1) == 0) magic = 16'($urandom);
        cut = $urandom_range(1, HeaderBytes - 1);
      end
      FR_BAD_MAGIC: begin
        do magic = 16'($urandom); while (magic == cur_magic);
      end
      FR_BAD_VERSION: begin
        do ver = 8'($urandom); while (ver == cur_version);
      end
      FR_BAD_CHANNEL: begin
        case ($urandom_range(0, 3))
          0: chan = 8'd0;
          1: chan = 8'd6;
          2: chan = 8'd255;
          default: chan = 8'($urandom_range(6, 255));
        endcase
      end
      FR_ZERO_ID: req = '0;
      FR_ZERO_LENGTH: begin
        len = '0;
        n   = $urandom_range(0, 3);
      end
      FR_OVER_LIMIT: begin
        len = (lim > 32'hFFFF_FFEF) ? 32'hFFFF_FFFF : lim + $urandom_range(1, 16);
        n   = $urandom_range(0, 4);
      end
      FR_TOO_LONG: n = len + $urandom_range(1, 5);
      FR_TOO_SHORT: begin
        // Large declared lengths are only reachable when the payload stops early.
        if (lim > 1) begin
          if ($urandom_range(0, 1) == 0) len = $urandom_range(2, lim);
          else len = $urandom_range(2, (lim < 16) ? lim : 16);
          n = $urandom_range(1, (len - 1 < 8) ? len - 1 : 8);
        end else begin
          n = 0;
        end
      end
      FR_END_AT_HEADER: n = 0;
      FR_NOISE: begin
        magic = 16'($urandom);
        ver   = 8'($urandom);
        chan  = 8'($urandom);
        req   = {$urandom, $urandom};
        len   = $urandom;
        n     = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) cut = $urandom_range(1, HeaderBytes + n);
      end
      default: ;
    endcase
    hdr = {magic, ver, chan, kind, flags, req, len};
    for (int i = 0; i < HeaderBytes; i++) frame_q = {frame_q, hdr[159 - 8 * i -: 8]};
    repeat (n) frame_q = {frame_q, 8'($urandom)};
    if (cut != 0) begin
      while (frame_q.size() > cut) void'(frame_q.pop_back());
    end
    foreach (frame_q[i]) put_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  initial begin
    int unsigned   stop_at;
    frame_flavor_e flavor;
    rst_ni              = 1'b0;
    in_if.valid         = 1'b0;
    in_if.data_byte     = '0;
    in_if.end_of_frame  = 1'b0;
    out_if.ready        = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = '0;
    cfg_if.data         = '0;
    cur_magic           = '0;
    cur_version         = '0;
    cur_limit[0]        = Limit1Reset;
    cur_limit[1]        = Limit2Reset;
    cur_limit[2]        = Limit3Reset;
    cur_limit[3]        = Limit4Reset;
    cur_limit[4]        = Limit5Reset;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Register values straight out of reset.
    send_frame(FR_GOOD);
    send_frame(FR_END_AT_HEADER);
    send_frame(FR_SHORT_HEADER);
    drain_results();

    // All-ones magic and version with every limit at its minimum.
    foreach (next_limit[k]) next_limit[k] = 32'd1;
    apply_settings(16'hFFFF, 8'hFF, 8'd7);
    send_frame(FR_GOOD);
    send_frame(FR_TOO_LONG);
    send_frame(FR_TOO_SHORT);
    send_frame(FR_OVER_LIMIT);
    send_frame(FR_BAD_MAGIC);
    send_frame(FR_BAD_VERSION);
    send_frame(FR_BAD_CHANNEL);
    send_frame(FR_ZERO_ID);
    send_frame(FR_ZERO_LENGTH);
    send_frame(FR_NOISE);
    drain_results();

    // Every limit at its maximum.
    foreach (next_limit[k]) next_limit[k] = 32'hFFFF_FFFF;
    apply_settings(16'h0000, 8'h00, 8'd255);
    send_frame(FR_TOO_SHORT);
    send_frame(FR_TOO_SHORT);
    send_frame(FR_OVER_LIMIT);
    send_frame(FR_GOOD);

    for (int ph = 0; ph < 6; ph++) begin
      drain_results();
      foreach (next_limit[k]) begin
        case ($urandom_range(0, 3))
          0: next_limit[k] = 32'd1;
          1: next_limit[k] = $urandom_range(1, 40);
          2: next_limit[k] = $urandom_range(1, 32'hFFFF_FFFF);
          default: next_limit[k] = 32'hFFFF_FFFF;
        endcase
      end
      apply_settings(16'($urandom), 8'($urandom), 8'($urandom_range(7, 255)));
      stop_at = bytes_sent + 210;
      while (bytes_sent < stop_at) begin
        // Mostly legal frames, so that the payload path is well exercised.
        if ($urandom_range(0, 99) < 55) flavor = FR_GOOD;
        else flavor = frame_flavor_e'($urandom_range(FR_SHORT_HEADER, FR_NOISE));
        send_frame(flavor);
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/efc_pkg.sv
rtl/efc_intf.sv
rtl/efc_cfg_regs.sv
rtl/envelope_frame_checker.sv
test/efc_record_checker.sv
test/testbench.sv
